FILE: src/sss_pkg.sv
package sss_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_SCAN   = 3'd7;

    localparam logic [1:0] ACT_STEP   = 2'd0;
    localparam logic [1:0] ACT_SCAN_A = 2'd1;
    localparam logic [1:0] ACT_SCAN_B = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned ANGLE_W = 9;
    localparam int unsigned PULSE_W = 12;
    localparam int unsigned DIST_W  = 9;
    localparam int unsigned PROD_W  = ANGLE_W + PULSE_W;

    localparam logic signed [10:0] DEG_FULL = 11'sd360;
    localparam logic signed [10:0] DEG_HALF = 11'sd180;

    localparam logic [9:0] MAX_DISTANCE_CM = 10'd500;

    typedef struct packed {
        logic [31:0]       now_ms;
        logic [DIST_W-1:0] distance_a_cm;
        logic [DIST_W-1:0] distance_b_cm;
    } t_in;

    typedef struct packed {
        logic [1:0]         action;
        logic [PULSE_W-1:0] servo_pulse_us;
        logic [ANGLE_W-1:0] heading_deg;
        logic [DIST_W-1:0]  distance_cm;
        logic [31:0]        capture_ms;
    } t_out;

endpackage

FILE: src/sss_div.sv
module sss_div #(
    parameter int unsigned NUM_W = 21,
    parameter int unsigned DEN_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_work;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic             w_ge;
    logic [DEN_W:0]   w_sub;

    // restoring division, one quotient bit a cycle
    assign w_shift = {r_rem, r_work[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
                r_work <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_work <= {r_work[NUM_W-2:0], w_ge};
                r_rem  <= w_ge ? w_sub[DEN_W-1:0] : w_shift[DEN_W-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

FILE: src/servo_sonar_sweep_sequencer_core.sv
// Servo sweep and dual sonar scan sequencer. Each input item is a time tick
// (millisecond count plus both sonars' latest distances). The block cycles
// through a servo step, a scan of the first sonar and a scan of the second;
// a phase fires once its pause has elapsed since the last firing and then
// yields one result item, otherwise the tick yields none. The block takes
// one tick at a time and stalls its input while working. A servo step
// computes its pulse width with the restoring divider, one quotient bit
// a cycle over the 21-bit pulse product; unless the maximum angle exceeds
// the minimum, the step skips the divider. A finished result waits in an
// output register, so the next tick can be taken while it is still held;
// a further result waits for that register to drain, with the input
// stalled meanwhile.
// Configuration writes belong in idle periods.
module servo_sonar_sweep_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sss_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sss_pkg::t_out                       o_out,
    input  logic                                i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sss_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STEP,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    logic [sss_pkg::ANGLE_W-1:0] r_angle_min;
    logic [sss_pkg::ANGLE_W-1:0] r_angle_max;
    logic [7:0]                  r_angle_step;
    logic [7:0]                  r_angle_offset;
    logic [sss_pkg::PULSE_W-1:0] r_pw_min;
    logic [sss_pkg::PULSE_W-1:0] r_pw_max;
    logic [15:0]                 r_pause_step;
    logic [15:0]                 r_pause_scan;

    logic [1:0]                  r_phase;
    logic                        r_sweep_down;
    logic [sss_pkg::ANGLE_W-1:0] r_cur;
    logic [31:0]                 r_last;

    sss_pkg::t_in                r_tick;
    logic                        r_neg;
    sss_pkg::t_out               r_res;
    logic                        r_out_valid;
    sss_pkg::t_out               r_out;

    logic                        w_stepping;
    logic [31:0]                 w_due;
    logic                        w_fire;
    logic signed [10:0]          w_a;
    logic signed [10:0]          w_amax;
    logic signed [10:0]          w_amin;
    logic                        w_over;
    logic                        w_under;
    logic [sss_pkg::ANGLE_W-1:0] w_a_clamp;
    logic                        w_scan_b;
    logic signed [10:0]          w_h0;
    logic signed [10:0]          w_h;
    logic [sss_pkg::DIST_W-1:0]  w_dist_raw;
    logic [sss_pkg::DIST_W-1:0]  w_dist;
    logic [sss_pkg::ANGLE_W-1:0] w_span;
    logic [sss_pkg::ANGLE_W-1:0] w_den;
    logic signed [12:0]          w_diff;
    logic [sss_pkg::PULSE_W-1:0] w_mag;
    logic [sss_pkg::PROD_W-1:0]  w_prod;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [sss_pkg::PROD_W-1:0]  w_quot;
    logic [12:0]                 w_q_ext;
    logic [12:0]                 w_pulse_sum;
    logic                        w_out_free;

    assign w_stepping = (r_phase == sss_pkg::ACT_STEP) || (r_phase == sss_pkg::ACT_UNUSED);
    assign w_due      = r_last + (w_stepping ? {16'd0, r_pause_step} : {16'd0, r_pause_scan});
    assign w_fire     = (r_tick.now_ms >= w_due);

    // servo step with clamp at either limit
    assign w_amax    = $signed({2'b00, r_angle_max});
    assign w_amin    = $signed({2'b00, r_angle_min});
    assign w_a       = r_sweep_down ? $signed({2'b00, r_cur}) - $signed({3'b000, r_angle_step})
                                    : $signed({2'b00, r_cur}) + $signed({3'b000, r_angle_step});
    assign w_over    = (w_a > w_amax);
    assign w_under   = !w_over && (w_a < w_amin);
    assign w_a_clamp = w_over ? r_angle_max : (w_under ? r_angle_min : w_a[8:0]);

    // scan heading, single wrap correction
    assign w_scan_b = (r_phase == sss_pkg::ACT_SCAN_B);
    assign w_h0     = $signed({2'b00, r_cur}) - (w_scan_b ? sss_pkg::DEG_HALF : 11'sd0)
                      - $signed({3'b000, r_angle_offset});
    always_comb begin
        priority if (w_h0 > sss_pkg::DEG_FULL) begin
            w_h = w_h0 - sss_pkg::DEG_FULL;
        end else if (w_h0 < 11'sd0) begin
            w_h = w_h0 + sss_pkg::DEG_FULL;
        end else begin
            w_h = w_h0;
        end
    end

    assign w_dist_raw = w_scan_b ? r_tick.distance_b_cm : r_tick.distance_a_cm;
    assign w_dist     = ({1'b0, w_dist_raw} > sss_pkg::MAX_DISTANCE_CM) ? '0 : w_dist_raw;

    // pulse map: pw_max moved toward pw_min by (angle - min) * |pw_min - pw_max| / (max - min)
    assign w_span      = r_cur - r_angle_min;
    assign w_den       = r_angle_max - r_angle_min;
    assign w_diff      = $signed({1'b0, r_pw_min}) - $signed({1'b0, r_pw_max});
    assign w_mag       = w_diff[12] ? 12'(-w_diff) : w_diff[11:0];
    assign w_prod      = {{(sss_pkg::PROD_W-sss_pkg::ANGLE_W){1'b0}}, w_span}
                         * {{(sss_pkg::PROD_W-sss_pkg::PULSE_W){1'b0}}, w_mag};
    assign w_div_start = (r_state == S_MUL);

    sss_div #(
        .NUM_W (sss_pkg::PROD_W),
        .DEN_W (sss_pkg::ANGLE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_q_ext     = {1'b0, w_quot[sss_pkg::PULSE_W-1:0]};
    assign w_pulse_sum = {1'b0, r_pw_max} + (r_neg ? (13'd0 - w_q_ext) : w_q_ext);

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_angle_min    <= 9'd0;
            r_angle_max    <= 9'd180;
            r_angle_step   <= 8'd10;
            r_angle_offset <= 8'd90;
            r_pw_min       <= 12'd1000;
            r_pw_max       <= 12'd2000;
            r_pause_step   <= 16'd100;
            r_pause_scan   <= 16'd50;
            r_phase        <= sss_pkg::ACT_STEP;
            r_sweep_down   <= 1'b0;
            r_cur          <= '0;
            r_last         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sss_pkg::CFG_ANGLE_MIN:    r_angle_min    <= i_cfg_wdata[8:0];
                    sss_pkg::CFG_ANGLE_MAX:    r_angle_max    <= i_cfg_wdata[8:0];
                    sss_pkg::CFG_ANGLE_STEP:   r_angle_step   <= i_cfg_wdata[7:0];
                    sss_pkg::CFG_ANGLE_OFFSET: r_angle_offset <= i_cfg_wdata[7:0];
                    sss_pkg::CFG_SERVO_MIN:    r_pw_min       <= i_cfg_wdata[11:0];
                    sss_pkg::CFG_SERVO_MAX:    r_pw_max       <= i_cfg_wdata[11:0];
                    sss_pkg::CFG_PAUSE_STEP:   r_pause_step   <= i_cfg_wdata;
                    sss_pkg::CFG_PAUSE_SCAN:   r_pause_scan   <= i_cfg_wdata;
                endcase
            end

            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tick  <= i_in;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_fire) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_last             <= r_tick.now_ms;
                        r_res.capture_ms   <= r_tick.now_ms;
                        if (w_stepping) begin
                            r_state <= S_STEP;
                        end else begin
                            r_res.action         <= r_phase;
                            r_res.servo_pulse_us <= '0;
                            r_res.heading_deg    <= w_h[8:0];
                            r_res.distance_cm    <= w_dist;
                            r_phase <= w_scan_b ? sss_pkg::ACT_STEP : sss_pkg::ACT_SCAN_B;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_STEP: begin
                    r_cur                <= w_a_clamp;
                    r_sweep_down         <= r_sweep_down ^ (w_over || w_under);
                    r_phase              <= sss_pkg::ACT_SCAN_A;
                    r_res.action         <= sss_pkg::ACT_STEP;
                    r_res.heading_deg    <= '0;
                    r_res.distance_cm    <= '0;
                    r_res.servo_pulse_us <= r_pw_max;
                    r_state <= (r_angle_max > r_angle_min) ? S_MUL : S_OUT;
                end
                S_MUL: begin
                    r_neg   <= w_diff[12];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res.servo_pulse_us <= w_pulse_sum[sss_pkg::PULSE_W-1:0];
                        r_state              <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_phase_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != sss_pkg::ACT_UNUSED)
        else $error("unused phase reached");

    a_angle_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_angle_max >= r_angle_min) |=>
            (r_cur >= r_angle_min && r_cur <= r_angle_max))
        else $error("servo angle outside sweep limits");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    a_step_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == sss_pkg::ACT_STEP) |->
            (r_out.heading_deg == '0 && r_out.distance_cm == '0))
        else $error("servo step item carries scan fields");

    a_scan_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action != sss_pkg::ACT_STEP) |->
            (r_out.servo_pulse_us == '0))
        else $error("scan item carries a pulse width");

endmodule
